FILE: hw/rtl/gpke_pkg.sv
// ----------------------------------------------------------------------------
// gpke_pkg: shared types and constants for the gamepad report decoder
// Report type codes, register indexes, event slot layout and the job record
// passed from the report parser to the event generator.
// ----------------------------------------------------------------------------
package gpke_pkg;

  // Configuration port
  localparam int REG_IDX_W = 3;
  localparam int REG_W     = 16;
  localparam int THR_W     = 15;

  localparam logic [REG_IDX_W-1:0] REG_LT_THR = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RT_THR = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LX_THR = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LY_THR = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RX_THR = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_RY_THR = 3'd5;

  localparam logic [THR_W-1:0] STICK_THR_RESET = 15'd8000;

  // Report framing
  localparam logic [7:0] TYPE_INPUT = 8'h20;
  localparam logic [7:0] TYPE_GUIDE = 8'h07;
  localparam logic [4:0] FULL_LEN   = 5'd18;
  localparam logic [4:0] GUIDE_LEN  = 5'd5;
  localparam logic [4:0] POS_MAX    = 5'd31;
  localparam logic [4:0] POS_BTN_LO = 5'd4;
  localparam logic [4:0] POS_BTN_HI = 5'd5;
  localparam logic [4:0] POS_ANA_LO = 5'd6;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_INPUT = 2'd1,
    KIND_GUIDE = 2'd2
  } report_kind_t;

  // Button flag bits that get special handling
  localparam int BTN_GUIDE = 14;
  localparam int BTN_SYNC  = 15;

  // Event slots in emission order: 14 buttons, 10 analog directions, guide
  localparam int NUM_SLOTS     = 25;
  localparam int NUM_BTN_SLOTS = 14;
  localparam int NUM_ANA       = 10;
  localparam int SLOT_GUIDE    = 24;

  typedef logic [4:0] code_t;

  localparam code_t SLOT_CODE [NUM_SLOTS] = '{
    5'd0,  5'd1,  5'd2,  5'd3,  5'd15, 5'd14, 5'd9,  5'd11, 5'd8,  5'd10,
    5'd6,  5'd7,  5'd12, 5'd13,
    5'd4,  5'd5,  5'd20, 5'd18, 5'd19, 5'd21, 5'd24, 5'd22, 5'd23, 5'd25,
    5'd17
  };

  // One finished report, already compared against thresholds
  typedef struct packed {
    logic                guide;
    logic [15:0]         btn_lvl;
    logic [NUM_ANA-1:0]  ana_lvl;
  } job_t;

  function automatic report_kind_t classify(input logic [7:0] b);
    if (b == TYPE_INPUT) begin
      return KIND_INPUT;
    end else if (b == TYPE_GUIDE) begin
      return KIND_GUIDE;
    end
    return KIND_OTHER;
  endfunction

endpackage

FILE: hw/rtl/gpke_if.sv
// ----------------------------------------------------------------------------
// gpke_if: stream channels of the gamepad report decoder
// Report byte channel in, key event channel out; valid/ready handshake.
// ----------------------------------------------------------------------------
interface gpke_report_if;
  logic       valid;
  logic       ready;
  logic [7:0] report_byte;
  logic       report_end;

  modport source (output valid, report_byte, report_end, input ready);
  modport sink   (input valid, report_byte, report_end, output ready);
endinterface

interface gpke_event_if;
  logic       valid;
  logic       ready;
  logic [4:0] control_code;
  logic       is_press;
  logic       last_event;

  modport source (output valid, control_code, is_press, last_event, input ready);
  modport sink   (input valid, control_code, is_press, last_event, output ready);
endinterface

FILE: hw/rtl/gpke_front.sv
// ----------------------------------------------------------------------------
// gpke_front: report parser
// Takes report bytes, captures buttons and analog values, holds thresholds,
// and at the end of a valid report hands a compared job to the queue.
// ----------------------------------------------------------------------------
module gpke_front import gpke_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  gpke_report_if.sink          report,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [REG_W-1:0]     wr_data,
  output job_t                 job,
  output logic                 job_valid,
  input  logic                 job_full
);

  logic [4:0]       pos;
  report_kind_t     kind;
  logic             pend;
  logic             pend_guide;
  logic [15:0]      buttons;
  logic [15:0]      analog [6];
  logic [15:0]      thr_lt;
  logic [15:0]      thr_rt;
  logic [THR_W-1:0] thr_stick [4];

  logic             beat;
  report_kind_t     kind_now;
  logic [4:0]       pos_inc;
  logic [4:0]       ana_off;
  logic             good;

  assign beat      = report.valid && report.ready;
  assign report.ready = !pend || !job_full;
  assign job_valid = pend;

  // Framing
  always_comb begin
    kind_now = (pos == '0) ? classify(report.report_byte) : kind;
    pos_inc  = (pos == POS_MAX) ? pos : pos + 5'd1;
    ana_off  = pos - POS_ANA_LO;
    good     = ((kind_now == KIND_INPUT) && (pos_inc >= FULL_LEN)) ||
               ((kind_now == KIND_GUIDE) && (pos_inc >= GUIDE_LEN));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      kind <= KIND_OTHER;
      pend <= 1'b0;
    end else begin
      if (pend && !job_full) begin
        pend <= 1'b0;
      end
      if (beat) begin
        if (report.report_end) begin
          pos  <= '0;
          kind <= KIND_OTHER;
          pend <= good;
        end else begin
          pos  <= pos_inc;
          kind <= kind_now;
        end
      end
    end
  end

  // Payload capture
  always_ff @(posedge clk) begin
    if (beat) begin
      if (report.report_end) begin
        pend_guide <= (kind_now == KIND_GUIDE);
      end
      if (pos == POS_BTN_LO) begin
        buttons[7:0] <= report.report_byte;
      end else if (pos == POS_BTN_HI) begin
        buttons[15:8] <= report.report_byte;
      end else if ((pos >= POS_ANA_LO) && (pos < FULL_LEN)) begin
        if (pos[0]) begin
          analog[ana_off[3:1]][15:8] <= report.report_byte;
        end else begin
          analog[ana_off[3:1]][7:0] <= report.report_byte;
        end
      end
    end
  end

  // Threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr_lt <= '0;
      thr_rt <= '0;
      for (int i = 0; i < 4; i++) begin
        thr_stick[i] <= STICK_THR_RESET;
      end
    end else if (wr_en) begin
      case (wr_index)
        REG_LT_THR: thr_lt       <= wr_data;
        REG_RT_THR: thr_rt       <= wr_data;
        REG_LX_THR: thr_stick[0] <= wr_data[THR_W-1:0];
        REG_LY_THR: thr_stick[1] <= wr_data[THR_W-1:0];
        REG_RX_THR: thr_stick[2] <= wr_data[THR_W-1:0];
        REG_RY_THR: thr_stick[3] <= wr_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Level compare of the captured report
  always_comb begin
    logic signed [16:0] v;
    logic signed [16:0] t;
    job.guide   = pend_guide;
    job.btn_lvl = {buttons[0], buttons[0], buttons[15:8], buttons[3], buttons[2],
                   buttons[7:4]};
    job.ana_lvl[0] = analog[0] > thr_lt;
    job.ana_lvl[1] = analog[1] > thr_rt;
    for (int k = 0; k < 4; k++) begin
      v = {analog[2+k][15], analog[2+k]};
      t = {2'b00, thr_stick[k]};
      job.ana_lvl[2+2*k] = v > t;
      job.ana_lvl[3+2*k] = v < -t;
    end
  end

endmodule

FILE: hw/rtl/gpke_job_fifo.sv
// ----------------------------------------------------------------------------
// gpke_job_fifo: job queue between parser and event generator
// Small circular queue of compared reports; push and pop in the same cycle.
// ----------------------------------------------------------------------------
module gpke_job_fifo import gpke_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output job_t pop_data,
  output logic nonempty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_FULL);
  assign nonempty = (count != '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/gpke_back.sv
// ----------------------------------------------------------------------------
// gpke_back: event generator
// Keeps the pressed flags, diffs each job against them and emits one press
// or release event per unstalled cycle in slot order via an output register.
// ----------------------------------------------------------------------------
module gpke_back import gpke_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  job_t         head,
  input  logic         head_valid,
  output logic         pop,
  gpke_event_if.source key_events
);

  logic [15:0]          btn_flags;
  logic [NUM_ANA-1:0]   ana_flags;
  logic [NUM_SLOTS-1:0] mask;
  logic [NUM_SLOTS-1:0] lvl;
  logic                 out_valid;
  code_t                out_code;
  logic                 out_press;
  logic                 out_last;

  logic [15:0]          btn_next;
  logic [NUM_ANA-1:0]   ana_next;
  logic [NUM_SLOTS-1:0] chg;
  logic [NUM_SLOTS-1:0] slot_lvl;
  logic [NUM_SLOTS-1:0] lowest;
  logic [NUM_SLOTS-1:0] rest;
  code_t                pick_code;
  logic                 pick_press;
  logic                 can_emit;
  logic                 emit;

  // Diff of the queue head against current flags
  always_comb begin
    btn_next = btn_flags;
    ana_next = ana_flags;
    chg      = '0;
    slot_lvl = '0;
    if (head.guide) begin
      btn_next[BTN_GUIDE] = head.btn_lvl[BTN_GUIDE];
      chg[SLOT_GUIDE]     = head.btn_lvl[BTN_GUIDE] ^ btn_flags[BTN_GUIDE];
      slot_lvl[SLOT_GUIDE] = head.btn_lvl[BTN_GUIDE];
    end else begin
      // sync flag tracks silently
      btn_next[NUM_BTN_SLOTS-1:0] = head.btn_lvl[NUM_BTN_SLOTS-1:0];
      btn_next[BTN_SYNC]          = head.btn_lvl[BTN_SYNC];
      ana_next                    = head.ana_lvl;
      chg[NUM_BTN_SLOTS-1:0] = head.btn_lvl[NUM_BTN_SLOTS-1:0] ^
                               btn_flags[NUM_BTN_SLOTS-1:0];
      chg[NUM_BTN_SLOTS +: NUM_ANA] = head.ana_lvl ^ ana_flags;
      slot_lvl[NUM_BTN_SLOTS-1:0]      = head.btn_lvl[NUM_BTN_SLOTS-1:0];
      slot_lvl[NUM_BTN_SLOTS +: NUM_ANA] = head.ana_lvl;
    end
  end

  // Pick the first pending slot
  always_comb begin
    lowest     = mask & (~mask + 1'b1);
    rest       = mask & ~lowest;
    pick_press = |(lvl & lowest);
    pick_code  = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (lowest[s]) begin
        pick_code = pick_code | SLOT_CODE[s];
      end
    end
    can_emit = !out_valid || key_events.ready;
    emit     = can_emit && (mask != '0);
    // next job loads while the last event of this one goes out
    pop      = head_valid && ((mask == '0) || (emit && (rest == '0)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      btn_flags <= '0;
      ana_flags <= '0;
      mask      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        btn_flags <= btn_next;
        ana_flags <= ana_next;
        mask      <= chg;
      end else if (emit) begin
        mask <= rest;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (key_events.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Event payload
  always_ff @(posedge clk) begin
    if (pop) begin
      lvl <= slot_lvl;
    end
    if (emit) begin
      out_code  <= pick_code;
      out_press <= pick_press;
      out_last  <= (rest == '0);
    end
  end

  assign key_events.valid        = out_valid;
  assign key_events.control_code = out_code;
  assign key_events.is_press     = out_press;
  assign key_events.last_event   = out_last;

endmodule

FILE: hw/rtl/gamepad_report_to_key_events.sv
// ----------------------------------------------------------------------------
// gamepad_report_to_key_events: controller report to key event decoder
// Parses controller reports byte by byte and emits press/release events for
// every control whose pressed state changed at the end of a report.
// ----------------------------------------------------------------------------
// Channel      Dir  Beat payload                              Handshake
// report       in   report_byte[7:0], report_end              valid/ready
// key_events   out  control_code[4:0], is_press, last_event   valid/ready
// wr_*         in   wr_index[2:0], wr_data[15:0]              wr_en, no stall
//
// Report bytes are taken one per cycle; the parser stalls only when a
// finished report finds the job queue (QUEUE_DEPTH entries) full.
// Events leave at one per cycle from the generator's slot scan unless held
// by key_events backpressure, the next report loading in the cycle its last
// event is issued.
// Synchronous reset clears framing, flags, queue and output; no clearing pass.
// The output register holds an event under backpressure while parsing goes on.
// ----------------------------------------------------------------------------
module gamepad_report_to_key_events import gpke_pkg::*; #(
  parameter int QUEUE_DEPTH = 2  // 2 or more
) (
  input  logic                 clk,
  input  logic                 rst,
  gpke_report_if.sink          report,
  gpke_event_if.source         key_events,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [REG_W-1:0]     wr_data
);

  job_t job_in;
  job_t job_head;
  logic job_valid;
  logic job_full;
  logic job_pop;
  logic job_nonempty;

  gpke_front u_front (
    .clk       (clk),
    .rst       (rst),
    .report    (report),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .job       (job_in),
    .job_valid (job_valid),
    .job_full  (job_full)
  );

  gpke_job_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_valid && !job_full),
    .push_data (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .pop_data  (job_head),
    .nonempty  (job_nonempty)
  );

  gpke_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (job_head),
    .head_valid (job_nonempty),
    .pop        (job_pop),
    .key_events (key_events)
  );

  // Events of one report go out without gaps once one is taken
  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    (key_events.valid && key_events.ready && !key_events.last_event)
      |=> key_events.valid)
    else $error("event burst broken before last_event");

  // Input stalls only right after an end-of-report beat
  a_stall_after_end: assert property (@(posedge clk) disable iff (rst)
    $fell(report.ready) |-> $past(report.valid && report.report_end))
    else $error("input stalled without a finished report");

  // The generator only pops a queue that holds a job
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> job_nonempty)
    else $error("job queue popped while empty");

endmodule
